### hw/rtl/voxel_surface_cull_defines.svh
`ifndef VOXEL_SURFACE_CULL_DEFINES_SVH
`define VOXEL_SURFACE_CULL_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define VSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define VSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vsc_pkg.sv
package vsc_pkg;

  localparam int unsigned LOCAL_W   = 5;
  localparam int unsigned OUT_MAT_W = 16;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned POS_W     = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned CHUNK_SIZE_DEF    = 32;
  localparam int unsigned MATERIAL_BITS_DEF = 16;
  localparam int unsigned VOX_COUNT_DEF     = CHUNK_SIZE_DEF ** 3;
  localparam int unsigned VOX_AW_DEF        = $clog2(VOX_COUNT_DEF);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TEST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic                 valid;
    logic                 visible;
    logic [OUT_MAT_W-1:0] material;
    logic [LOCAL_W-1:0]   x;
    logic [LOCAL_W-1:0]   y;
    logic [LOCAL_W-1:0]   z;
  } result_t;

endpackage

### hw/rtl/vsc_store.sv
module vsc_store #(
  parameter int unsigned DEPTH  = vsc_pkg::VOX_COUNT_DEF,
  parameter int unsigned ADDR_W = vsc_pkg::VOX_AW_DEF,
  parameter int unsigned DATA_W = vsc_pkg::MATERIAL_BITS_DEF
) (
  input  logic              clk_i,
  input  vsc_pkg::mem_ctl_t ctl_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/vsc_seq.sv
module vsc_seq #(
  parameter int unsigned CHUNK_SIZE    = vsc_pkg::CHUNK_SIZE_DEF,
  parameter int unsigned MATERIAL_BITS = vsc_pkg::MATERIAL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                req_type_i,
  input  logic [vsc_pkg::LOCAL_W-1:0]         local_x_i,
  input  logic [vsc_pkg::LOCAL_W-1:0]         local_y_i,
  input  logic [vsc_pkg::LOCAL_W-1:0]         local_z_i,
  input  logic [vsc_pkg::OUT_MAT_W-1:0]       write_material_i,
  output vsc_pkg::mem_ctl_t                   mem_ctl_o,
  output logic [$clog2(CHUNK_SIZE**3)-1:0]    mem_addr_o,
  output logic [MATERIAL_BITS-1:0]            mem_wdata_o,
  input  logic [MATERIAL_BITS-1:0]            mem_rdata_i,
  output vsc_pkg::result_t                    result_o
);

  localparam int unsigned VOX_COUNT = CHUNK_SIZE ** 3;
  localparam int unsigned ADDR_W    = $clog2(VOX_COUNT);
  localparam int unsigned LW        = vsc_pkg::LOCAL_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VOX_COUNT - 1);
  localparam logic [ADDR_W-1:0] OFS_Y     = ADDR_W'(CHUNK_SIZE);
  localparam logic [ADDR_W-1:0] OFS_Z     = ADDR_W'(CHUNK_SIZE * CHUNK_SIZE);
  localparam logic [ADDR_W-1:0] OFS_X     = ADDR_W'(1);

  localparam logic [2:0] NB_LAST = 3'd5;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_CENTER = 2'd2;
  localparam logic [1:0] ST_NEIGH  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [LW-1:0]           x_q, x_d, y_q, y_d, z_q, z_d;
  logic                    border_q, border_d;
  logic [2:0]              nb_q, nb_d;
  logic [MATERIAL_BITS-1:0] mat_q, mat_d;

  logic              in_chunk;
  logic              in_border;
  logic [ADDR_W-1:0] in_addr;

  function automatic logic [ADDR_W-1:0] nb_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [2:0] k);
    logic [ADDR_W-1:0] a;
    unique case (k)
      3'd0:    a = base - OFS_X;
      3'd1:    a = base + OFS_X;
      3'd2:    a = base - OFS_Y;
      3'd3:    a = base + OFS_Y;
      3'd4:    a = base - OFS_Z;
      3'd5:    a = base + OFS_Z;
      default: a = base;
    endcase
    return a;
  endfunction

  assign in_chunk = (32'(local_x_i) < 32'(CHUNK_SIZE)) &&
                    (32'(local_y_i) < 32'(CHUNK_SIZE)) &&
                    (32'(local_z_i) < 32'(CHUNK_SIZE));

  assign in_border = (local_x_i == '0) || (local_y_i == '0) || (local_z_i == '0) ||
                     (32'(local_x_i) == 32'(CHUNK_SIZE - 1)) ||
                     (32'(local_y_i) == 32'(CHUNK_SIZE - 1)) ||
                     (32'(local_z_i) == 32'(CHUNK_SIZE - 1));

  assign in_addr = ADDR_W'((ADDR_W'(local_z_i) * OFS_Y + ADDR_W'(local_y_i)) * OFS_Y)
                 + ADDR_W'(local_x_i);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    border_d = border_q;
    nb_d     = nb_q;
    mat_d    = mat_q;

    mem_ctl_o   = '0;
    mem_addr_o  = in_addr;
    mem_wdata_o = MATERIAL_BITS'(write_material_i);

    result_o          = '0;
    result_o.x        = x_q;
    result_o.y        = y_q;
    result_o.z        = z_q;
    result_o.material = vsc_pkg::OUT_MAT_W'(mat_q);

    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_addr_o      = clr_q;
        mem_wdata_o     = '0;
        clr_d           = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == vsc_pkg::REQ_WRITE) begin
            mem_ctl_o.wr_en = in_chunk;
          end else begin
            x_d      = local_x_i;
            y_d      = local_y_i;
            z_d      = local_z_i;
            addr_d   = in_addr;
            border_d = in_border;
            if (in_chunk) begin
              mem_ctl_o.rd_en = 1'b1;
              state_d         = ST_CENTER;
            end else begin
              result_o.valid    = 1'b1;
              result_o.visible  = 1'b0;
              result_o.material = '0;
              result_o.x        = local_x_i;
              result_o.y        = local_y_i;
              result_o.z        = local_z_i;
            end
          end
        end
      end
      ST_CENTER: begin
        mat_d = mem_rdata_i;
        if ((mem_rdata_i == '0) || border_q) begin
          result_o.valid    = 1'b1;
          result_o.visible  = (mem_rdata_i != '0);
          result_o.material = vsc_pkg::OUT_MAT_W'(mem_rdata_i);
          state_d           = ST_IDLE;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          mem_addr_o      = nb_addr(addr_q, 3'd0);
          nb_d            = 3'd0;
          state_d         = ST_NEIGH;
        end
      end
      ST_NEIGH: begin
        if ((mem_rdata_i == '0) || (nb_q == NB_LAST)) begin
          result_o.valid   = 1'b1;
          result_o.visible = (mem_rdata_i == '0);
          state_d          = ST_IDLE;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          mem_addr_o      = nb_addr(addr_q, 3'(nb_q + 3'd1));
          nb_d            = 3'(nb_q + 3'd1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    border_q <= border_d;
    nb_q     <= nb_d;
    mat_q    <= mat_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### hw/rtl/voxel_surface_cull.sv
// Visibility test over one cubic chunk of CHUNK_SIZE^3 voxel materials held in a
// single-port synchronous memory that is read one entry per cycle. A write item
// is done without leaving the idle state. A test item outside the chunk reads no
// memory; a test on the chunk border or of an empty voxel makes only the center
// read; an interior test makes the center read followed by up to six neighbor
// reads, stopping at the first empty neighbor. After reset the block clears all
// CHUNK_SIZE^3 memory entries (32768 at the default size), one entry a cycle, with
// busy high; configuration writes are taken meanwhile. Each result is shown for one
// cycle on result_valid_o from output registers loaded when the sequencer has its
// answer, and the receiver cannot stall it. Configuration writes are always ready
// and must come only while the block is idle.
`include "voxel_surface_cull_defines.svh"

module voxel_surface_cull #(
  parameter int unsigned CHUNK_SIZE    = vsc_pkg::CHUNK_SIZE_DEF,
  parameter int unsigned MATERIAL_BITS = vsc_pkg::MATERIAL_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   req_type_i,
  input  logic [vsc_pkg::LOCAL_W-1:0]            local_x_i,
  input  logic [vsc_pkg::LOCAL_W-1:0]            local_y_i,
  input  logic [vsc_pkg::LOCAL_W-1:0]            local_z_i,
  input  logic [vsc_pkg::OUT_MAT_W-1:0]          write_material_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic signed [vsc_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                                   result_valid_o,
  output logic                                   visible_o,
  output logic signed [vsc_pkg::POS_W-1:0]       world_x_o,
  output logic signed [vsc_pkg::POS_W-1:0]       world_y_o,
  output logic signed [vsc_pkg::POS_W-1:0]       world_z_o,
  output logic [vsc_pkg::OUT_MAT_W-1:0]          voxel_material_o
);

  localparam int unsigned VOX_COUNT = CHUNK_SIZE ** 3;
  localparam int unsigned ADDR_W    = $clog2(VOX_COUNT);
  localparam int unsigned PW        = vsc_pkg::POS_W;
  localparam int unsigned CW        = vsc_pkg::CFG_W;
  localparam int unsigned LW        = vsc_pkg::LOCAL_W;

  logic [CW-1:0] chunk_x_q, chunk_y_q, chunk_z_q;

  logic                      res_valid_q;
  logic                      visible_q;
  logic [PW-1:0]             world_x_q, world_y_q, world_z_q;
  logic [vsc_pkg::OUT_MAT_W-1:0] material_q;

  vsc_pkg::mem_ctl_t        mem_ctl;
  logic [ADDR_W-1:0]        mem_addr;
  logic [MATERIAL_BITS-1:0] mem_wdata;
  logic [MATERIAL_BITS-1:0] mem_rdata;
  vsc_pkg::result_t         result;

  logic in_chunk;

  function automatic logic [PW-1:0] world_pos(input logic [LW-1:0] loc,
                                              input logic [CW-1:0] chunk);
    logic [PW-1:0] c;
    c = {{(PW - CW){chunk[CW-1]}}, chunk};
    return PW'(c * PW'(CHUNK_SIZE)) + PW'(loc);
  endfunction

  vsc_seq #(
    .CHUNK_SIZE   (CHUNK_SIZE),
    .MATERIAL_BITS(MATERIAL_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .req_type_i      (req_type_i),
    .local_x_i       (local_x_i),
    .local_y_i       (local_y_i),
    .local_z_i       (local_z_i),
    .write_material_i(write_material_i),
    .mem_ctl_o       (mem_ctl),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata),
    .result_o        (result)
  );

  vsc_store #(
    .DEPTH (VOX_COUNT),
    .ADDR_W(ADDR_W),
    .DATA_W(MATERIAL_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_x_q <= '0;
      chunk_y_q <= '0;
      chunk_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vsc_pkg::REG_CHUNK_X: chunk_x_q <= cfg_data_i;
        vsc_pkg::REG_CHUNK_Y: chunk_y_q <= cfg_data_i;
        vsc_pkg::REG_CHUNK_Z: chunk_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      visible_q  <= result.visible;
      material_q <= result.material;
      world_x_q  <= world_pos(result.x, chunk_x_q);
      world_y_q  <= world_pos(result.y, chunk_y_q);
      world_z_q  <= world_pos(result.z, chunk_z_q);
    end
  end

  assign result_valid_o   = res_valid_q;
  assign visible_o        = visible_q;
  assign voxel_material_o = material_q;
  assign world_x_o        = world_x_q;
  assign world_y_o        = world_y_q;
  assign world_z_o        = world_z_q;

  assign in_chunk = (32'(local_x_i) < 32'(CHUNK_SIZE)) &&
                    (32'(local_y_i) < 32'(CHUNK_SIZE)) &&
                    (32'(local_z_i) < 32'(CHUNK_SIZE));

  `VSC_ASSERT_NEXT(a_write_no_result, start && !busy && req_type_i == vsc_pkg::REQ_WRITE, !result_valid_o, "write item followed by a result")
  `VSC_ASSERT_NEXT(a_test_in_chunk_latency, start && !busy && req_type_i == vsc_pkg::REQ_TEST && in_chunk, !result_valid_o, "in-chunk test answered without a memory read")
  `VSC_ASSERT_NEXT(a_test_outside_result, start && !busy && req_type_i == vsc_pkg::REQ_TEST && !in_chunk, result_valid_o, "out-of-chunk test not answered next cycle")
  `VSC_ASSERT_NOW(a_outside_empty, result_valid_o && $past(start && !busy && req_type_i == vsc_pkg::REQ_TEST && !in_chunk), !visible_o && voxel_material_o == '0, "out-of-chunk test reported a voxel")

endmodule
